### design/stmr_pkg.sv
// Shared types, font table and color helpers for the scrolling text matrix renderer.
package stmr_pkg;

  localparam int MaxTextDefault     = 128;
  localparam int DisplayWidthDefault = 32;
  localparam int CharPitchDefault   = 6;

  localparam int GlyphCols = 5;
  localparam int NumGlyphs = 85;

  localparam logic [7:0] CodeFirst    = 8'h20;
  localparam logic [7:0] CodeLast     = 8'h7A;
  localparam logic [7:0] CodeLowerA   = 8'h61;
  localparam logic [6:0] GlyphLowerA  = 7'd59;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_TICK    = 2'd1,
    OP_RESTART = 2'd2
  } op_e;

  typedef enum logic [1:0] {
    CFG_TEXT_LENGTH    = 2'd0,
    CFG_FIXED_COLOR    = 2'd1,
    CFG_RAINBOW_MODE   = 2'd2,
    CFG_REPEAT_FOREVER = 2'd3
  } cfg_reg_e;

  typedef enum logic {
    ST_IDLE,
    ST_RUN
  } walk_state_e;

  typedef struct packed {
    logic [1:0] opcode;
    logic [6:0] char_slot;
    logic [7:0] char_code;
  } in_item_t;

  typedef struct packed {
    logic [4:0] column;
    logic [7:0] first_led;
    logic [7:0] led_bits;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last_column;
  } out_item_t;

  localparam logic [39:0] GLYPH_ROM [NumGlyphs] = '{
    40'h0000000000, 40'h3E5B4F5B3E, 40'h3E6B4F6B3E, 40'h1C3E7C3E1C, 40'h183C7E3C18,
    40'h1C577D571C, 40'h1C5E7F5E1C, 40'h00183C1800, 40'h007E424200, 40'h0042427E00,
    40'h2A1C7F1C2A, 40'h08083E0808, 40'h0080703000, 40'h0808080808, 40'h0000606000,
    40'h2010080402, 40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503, 40'h3649494936,
    40'h064949291E, 40'h0036360000, 40'h0056360000, 40'h0814224100, 40'h1414141414,
    40'h0041221408, 40'h0201510906, 40'h324979413E, 40'h7E1111117E, 40'h7F49494936,
    40'h3E41414122, 40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241, 40'h7F40404040,
    40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E, 40'h7F09090906, 40'h3E4151215E,
    40'h7F09192946, 40'h4649494931, 40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F,
    40'h3F4038403F, 40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h2054545478,
    40'h7F48444438, 40'h3844444420, 40'h384444487F, 40'h3854545418, 40'h087E090102,
    40'h0C5252523E, 40'h7F08040478, 40'h00447D4000, 40'h2040443D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438, 40'h7C14141408,
    40'h081414187C, 40'h7C08040408, 40'h4854545420, 40'h043F444020, 40'h3C4040207C,
    40'h1C2040201C, 40'h3C4030403C, 40'h4428102844, 40'h0C5050503C, 40'h4464544C44
  };

  function automatic logic [7:0] glyph_column(input logic [7:0] code, input logic [2:0] gc);
    logic [6:0]  g;
    logic [39:0] entry;
    logic [7:0]  col;
    col   = '0;
    g     = (code >= CodeLowerA) ? 7'(code - CodeLowerA) + GlyphLowerA
                                 : 7'(code - CodeFirst);
    entry = GLYPH_ROM[g];
    if (code >= CodeFirst && code <= CodeLast) begin
      case (gc)
        3'd0:    col = entry[39:32];
        3'd1:    col = entry[31:24];
        3'd2:    col = entry[23:16];
        3'd3:    col = entry[15:8];
        3'd4:    col = entry[7:0];
        default: col = '0;
      endcase
    end
    return col;
  endfunction

  function automatic logic [7:0] reverse8(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[k] = v[7-k];
    end
    return r;
  endfunction

  // returns {red, green, blue}
  function automatic logic [23:0] wheel(input logic [7:0] pos);
    logic [7:0] p;
    logic [7:0] q;
    logic [7:0] q3;
    logic [23:0] rgb;
    p = 8'd255 - pos;
    if (p < 8'd85) begin
      q   = p;
      q3  = 8'({1'b0, q, 1'b0} + {2'b00, q});
      rgb = {8'd255 - q3, 8'd0, q3};
    end else if (p < 8'd170) begin
      q   = p - 8'd85;
      q3  = 8'({1'b0, q, 1'b0} + {2'b00, q});
      rgb = {8'd0, q3, 8'd255 - q3};
    end else begin
      q   = p - 8'd170;
      q3  = 8'({1'b0, q, 1'b0} + {2'b00, q});
      rgb = {q3, 8'd255 - q3, 8'd0};
    end
    return rgb;
  endfunction

endpackage

### design/scrolling_text_matrix_renderer.sv
// Scrolling text renderer for a serpentine LED matrix: text memory, column walker, output stage.
// Write and restart items are taken whenever the walker is idle. A frame tick, unless the text
// has scrolled out with repeat off, walks the display columns, one text memory read per cycle
// through its single read port while out_stall_i does not hold the output, and stalls the input
// until the last column has been read; each column goes through the read data and stage-1
// registers into the output register. The next item is taken as soon as the last column has
// been read. Text memory has no reset or clearing pass: unwritten entries read as unknown codes.
module scrolling_text_matrix_renderer
  import stmr_pkg::*;
#(
  parameter int MAX_TEXT      = MaxTextDefault,
  parameter int DISPLAY_WIDTH = DisplayWidthDefault,
  parameter int CHAR_PITCH    = CharPitchDefault
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o,
  input  logic      cfg_valid_i,
  output logic      cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [23:0] cfg_data_i
);

  localparam int AW    = (MAX_TEXT > 1) ? $clog2(MAX_TEXT) : 1;
  localparam int CI_W  = $clog2(MAX_TEXT + 1);
  localparam int DW_W  = $clog2(DISPLAY_WIDTH);
  localparam int GC_W  = $clog2(CHAR_PITCH);
  localparam int POS_W = $clog2(MAX_TEXT * CHAR_PITCH + DISPLAY_WIDTH + 2) + 1;

  logic [7:0]  text_len_q;
  logic [23:0] fixed_color_q;
  logic        rainbow_q;
  logic        repeat_q;

  logic signed [POS_W-1:0] pos_q;
  logic                    done_q;
  logic [CI_W-1:0]         base_ci_q;
  logic [GC_W-1:0]         base_gc_q;

  walk_state_e     state_q, state_d;
  logic [DW_W-1:0] d_q;
  logic [CI_W-1:0] run_ci_q;
  logic [GC_W-1:0] run_gc_q;

  logic [7:0]      text_mem_q [MAX_TEXT];
  logic [7:0]      rdata_q;

  logic            s1_valid_q;
  logic [DW_W-1:0] s1_d_q;
  logic            s1_show_q;
  logic [GC_W-1:0] s1_gc_q;

  logic      out_valid_q;
  out_item_t out_q;

  logic       in_acc;
  op_e        op;
  logic       tick_start;
  logic       adv;
  logic       issue;
  logic       last_d;
  logic [8:0] used_len;
  logic       active;
  logic       show;
  logic       mem_we;
  logic [7:0] slot_ext;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_addr;
  logic signed [POS_W-1:0] pos_dec;
  logic signed [POS_W-1:0] neg_span;
  logic [7:0] hue_lut [DISPLAY_WIDTH];
  logic [7:0] line_raw;
  logic [7:0] line;
  logic [23:0] rgb;
  logic [7:0] d_ext;

  for (genvar i = 0; i < DISPLAY_WIDTH; i++) begin : g_hue
    assign hue_lut[i] = 8'((i * 256 / DISPLAY_WIDTH) & 255);
  end

  assign cfg_ready_o = 1'b1;
  assign op          = op_e'(in_data_i.opcode);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign tick_start  = in_acc && op == OP_TICK && (!done_q || repeat_q);
  assign adv         = !out_valid_q || !out_stall_i;
  assign last_d      = d_q == DW_W'(DISPLAY_WIDTH - 1);
  assign used_len    = ({1'b0, text_len_q} > 9'(MAX_TEXT)) ? 9'(MAX_TEXT) : {1'b0, text_len_q};
  assign active      = $signed(POS_W'(d_q)) >= pos_q;
  assign show        = active && 9'(run_ci_q) < used_len;
  assign slot_ext    = {1'b0, in_data_i.char_slot};
  assign wr_addr     = slot_ext[AW-1:0];
  assign rd_addr     = run_ci_q[AW-1:0];
  assign mem_we      = in_acc && op == OP_WRITE && 9'(slot_ext) < 9'(MAX_TEXT);
  assign pos_dec     = pos_q - POS_W'(1);
  assign neg_span    = -$signed(POS_W'(used_len) * POS_W'(CHAR_PITCH));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (tick_start) state_d = ST_RUN;
      ST_RUN:  if (adv && last_d) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall_o = state_q != ST_IDLE;
    issue      = state_q == ST_RUN && adv;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      text_len_q    <= '0;
      fixed_color_q <= 24'hFFFFFF;
      rainbow_q     <= 1'b0;
      repeat_q      <= 1'b0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_reg_e'(cfg_index_i))
        CFG_TEXT_LENGTH:    text_len_q    <= cfg_data_i[7:0];
        CFG_FIXED_COLOR:    fixed_color_q <= cfg_data_i;
        CFG_RAINBOW_MODE:   rainbow_q     <= cfg_data_i[0];
        CFG_REPEAT_FOREVER: repeat_q      <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      d_q       <= '0;
      run_ci_q  <= '0;
      run_gc_q  <= '0;
      pos_q     <= POS_W'(DISPLAY_WIDTH);
      done_q    <= 1'b0;
      base_ci_q <= '0;
      base_gc_q <= '0;
    end else begin
      state_q <= state_d;
      if (in_acc && op == OP_RESTART) begin
        pos_q     <= POS_W'(DISPLAY_WIDTH);
        done_q    <= 1'b0;
        base_ci_q <= '0;
        base_gc_q <= '0;
      end
      if (tick_start) begin
        d_q      <= '0;
        run_ci_q <= base_ci_q;
        run_gc_q <= base_gc_q;
      end
      if (issue) begin
        d_q <= d_q + DW_W'(1);
        if (active) begin
          if (run_gc_q == GC_W'(CHAR_PITCH - 1)) begin
            run_gc_q <= '0;
            if (run_ci_q != CI_W'(MAX_TEXT)) run_ci_q <= run_ci_q + CI_W'(1);
          end else begin
            run_gc_q <= run_gc_q + GC_W'(1);
          end
        end
        if (last_d) begin
          if (pos_dec < neg_span && repeat_q) begin
            pos_q     <= POS_W'(DISPLAY_WIDTH);
            base_ci_q <= '0;
            base_gc_q <= '0;
          end else begin
            pos_q <= pos_dec;
            if (pos_dec < neg_span) done_q <= 1'b1;
            if (pos_q <= $signed(POS_W'(0))) begin
              if (base_gc_q == GC_W'(CHAR_PITCH - 1)) begin
                base_gc_q <= '0;
                if (base_ci_q != CI_W'(MAX_TEXT)) base_ci_q <= base_ci_q + CI_W'(1);
              end else begin
                base_gc_q <= base_gc_q + GC_W'(1);
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) text_mem_q[wr_addr] <= in_data_i.char_code;
    if (issue) rdata_q <= text_mem_q[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= issue;
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (issue) begin
      s1_d_q    <= d_q;
      s1_show_q <= show;
      s1_gc_q   <= run_gc_q;
    end
  end

  always_comb begin
    line_raw = s1_show_q ? glyph_column(rdata_q, 3'(s1_gc_q)) : 8'd0;
    line     = s1_d_q[0] ? reverse8(line_raw) : line_raw;
    rgb      = rainbow_q ? wheel(hue_lut[s1_d_q]) : fixed_color_q;
    d_ext    = 8'(s1_d_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv && s1_valid_q) begin
      out_q.column      <= d_ext[4:0];
      out_q.first_led   <= {d_ext[4:0], 3'b000};
      out_q.led_bits    <= line;
      out_q.red         <= rgb[23:16];
      out_q.green       <= rgb[15:8];
      out_q.blue        <= rgb[7:0];
      out_q.last_column <= s1_d_q == DW_W'(DISPLAY_WIDTH - 1);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= $signed(POS_W'(DISPLAY_WIDTH)) &&
    pos_q >= -$signed(POS_W'(MAX_TEXT * CHAR_PITCH + 1)))
    else $error("scroll position out of range");

  a_base_gc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_gc_q < GC_W'(CHAR_PITCH) && run_gc_q < GC_W'(CHAR_PITCH))
    else $error("glyph column counter past pitch");

  a_rdata_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !adv |=> $stable(rdata_q))
    else $error("read data lost while output stalled");

  a_idle_no_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |=> !s1_valid_q || $past(s1_valid_q) || $past(issue))
    else $error("column issued outside a frame");

endmodule
